FILE: rtl/alt_pkg.sv
`default_nettype none
package alt_pkg;

  localparam int unsigned SumW = 48;

  // register indexes on the configuration port
  localparam logic [2:0] REG_LEARN_RATE     = 3'd0;
  localparam logic [2:0] REG_INITIAL_WEIGHT = 3'd1;
  localparam logic [2:0] REG_INITIAL_BIAS   = 3'd2;
  localparam logic [2:0] REG_ERROR_LIMIT    = 3'd3;
  localparam logic [2:0] REG_MAX_EPOCHS     = 3'd4;

  localparam logic [15:0]        RST_LEARN_RATE  = 16'd13107;
  localparam logic signed [31:0] RST_WEIGHT      = 32'sd13107;
  localparam logic signed [31:0] RST_BIAS        = 32'sd13107;
  localparam logic [SumW-1:0]    RST_ERROR_LIMIT = 48'd65536;
  localparam logic [7:0]         RST_MAX_EPOCHS  = 8'd20;

  typedef struct packed {
    logic              mode;
    logic signed [7:0] sample_a;
    logic signed [7:0] sample_b;
    logic signed [7:0] target_value;
    logic              end_of_epoch;
  } in_t;

  typedef struct packed {
    logic signed [31:0] net_value;
    logic signed [31:0] error_value;
    logic signed [31:0] weight_a;
    logic signed [31:0] weight_b;
    logic signed [31:0] bias_value;
    logic [SumW-1:0]    epoch_error;
    logic [7:0]         epoch_number;
    logic               done_res;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_NET,
    ST_ERR,
    ST_RATE,
    ST_MUL,
    ST_UPD,
    ST_RESTART,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic net;
    logic err;
    logic rate;
    logic mul;
    logic upd;
    logic restart;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic item_mode;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/alt_ctrl.sv
`default_nettype none
module alt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          sample_valid,
  input  wire logic          start_mode,
  output logic               sample_ready,
  input  wire alt_pkg::sts_t sts,
  output alt_pkg::ctl_t      ctl
);

  alt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctl          = '0;
    sample_ready = 1'b0;
    case (state)
      alt_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          ctl.load   = 1'b1;
          state_next = start_mode ? alt_pkg::ST_RESTART : alt_pkg::ST_PROD;
        end
      end
      alt_pkg::ST_PROD: begin
        ctl.prod   = 1'b1;
        state_next = alt_pkg::ST_NET;
      end
      alt_pkg::ST_NET: begin
        ctl.net    = 1'b1;
        state_next = alt_pkg::ST_ERR;
      end
      alt_pkg::ST_ERR: begin
        ctl.err    = 1'b1;
        state_next = alt_pkg::ST_RATE;
      end
      alt_pkg::ST_RATE: begin
        ctl.rate   = 1'b1;
        state_next = alt_pkg::ST_MUL;
      end
      alt_pkg::ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = alt_pkg::ST_UPD;
      end
      alt_pkg::ST_UPD: begin
        ctl.upd    = 1'b1;
        state_next = alt_pkg::ST_FIN;
      end
      alt_pkg::ST_RESTART: begin
        ctl.restart = 1'b1;
        state_next  = alt_pkg::ST_FIN;
      end
      alt_pkg::ST_FIN: begin
        // hold here while the result word still waits
        if (sts.out_free) begin
          ctl.fin    = 1'b1;
          state_next = alt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = alt_pkg::ST_IDLE;
      end
    endcase
  end

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    ctl.fin |-> sts.out_free)
    else $error("result written while output register full");

  a_restart_fin: assert property (@(posedge clk) disable iff (rst)
    state == alt_pkg::ST_RESTART |=> state == alt_pkg::ST_FIN)
    else $error("restart not followed by finish");

  a_upd_train: assert property (@(posedge clk) disable iff (rst)
    ctl.upd |-> !sts.item_mode)
    else $error("weight update on a restart word");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> state != alt_pkg::ST_IDLE)
    else $error("accepted word did not start work");

endmodule
`default_nettype wire

FILE: rtl/alt_dp.sv
`default_nettype none
module alt_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire alt_pkg::in_t  sample,
  input  wire logic          cfg_valid,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [47:0]   cfg_data,
  input  wire logic          result_ready,
  output logic               result_valid,
  output alt_pkg::out_t      result,
  input  wire alt_pkg::ctl_t ctl,
  output alt_pkg::sts_t      sts
);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // configuration
  logic [15:0]                 learn_rate;
  logic signed [31:0]          init_weight;
  logic signed [31:0]          init_bias;
  logic [alt_pkg::SumW-1:0]    error_limit;
  logic [7:0]                  max_epochs;

  // training state
  logic signed [31:0]          wa, wb, bias;
  logic [alt_pkg::SumW-1:0]    esum;
  logic [7:0]                  ecount;
  logic                        done;

  // item and intermediate values
  alt_pkg::in_t                item;
  logic signed [39:0]          pa, pb;
  logic signed [31:0]          net, err;
  logic signed [48:0]          er;
  logic [63:0]                 sq;
  logic signed [56:0]          pwa, pwb;

  logic signed [41:0]          net_sum;
  logic signed [63:0]          err_diff;
  logic signed [56:0]          pwa_r, pwb_r;
  logic signed [48:0]          er_r;
  logic [63:0]                 sq_r;
  logic [alt_pkg::SumW:0]      sum_add;
  logic                        train;
  logic                        epoch_end;
  logic                        stop;

  assign net_sum = {{2{pa[39]}}, pa} + {{2{pb[39]}}, pb} + {{10{bias[31]}}, bias};
  assign err_diff = {{40{item.target_value[7]}}, item.target_value, 16'h0000}
                  - {{32{net[31]}}, net};

  // round half up, then arithmetic shift by 16
  assign pwa_r = pwa + 57'sd32768;
  assign pwb_r = pwb + 57'sd32768;
  assign er_r  = er + 49'sd32768;
  assign sq_r  = sq + 64'd32768;
  assign sum_add = {1'b0, esum} + {1'b0, sq_r[63:16]};

  assign train     = !item.mode && !done;
  assign epoch_end = train && item.end_of_epoch;
  assign stop      = epoch_end && ((esum <= error_limit) || (ecount > max_epochs));

  assign sts.item_mode = item.mode;
  assign sts.out_free  = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate  <= alt_pkg::RST_LEARN_RATE;
      init_weight <= alt_pkg::RST_WEIGHT;
      init_bias   <= alt_pkg::RST_BIAS;
      error_limit <= alt_pkg::RST_ERROR_LIMIT;
      max_epochs  <= alt_pkg::RST_MAX_EPOCHS;
    end else if (cfg_valid) begin
      case (cfg_index)
        alt_pkg::REG_LEARN_RATE:     learn_rate  <= cfg_data[15:0];
        alt_pkg::REG_INITIAL_WEIGHT: init_weight <= cfg_data[31:0];
        alt_pkg::REG_INITIAL_BIAS:   init_bias   <= cfg_data[31:0];
        alt_pkg::REG_ERROR_LIMIT:    error_limit <= cfg_data;
        alt_pkg::REG_MAX_EPOCHS:     max_epochs  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) item <= sample;
    if (ctl.prod) begin
      pa <= {{8{wa[31]}}, wa} * {{32{item.sample_a[7]}}, item.sample_a};
      pb <= {{8{wb[31]}}, wb} * {{32{item.sample_b[7]}}, item.sample_b};
    end
    if (ctl.net) net <= sat32({{22{net_sum[41]}}, net_sum});
    else if (ctl.restart) net <= '0;
    if (ctl.err) err <= sat32(err_diff);
    else if (ctl.restart) err <= '0;
    if (ctl.rate) er <= {33'b0, learn_rate} * {{17{err[31]}}, err};
    if (ctl.mul) begin
      sq  <= {{32{err[31]}}, err} * {{32{err[31]}}, err};
      pwa <= {{49{item.sample_a[7]}}, item.sample_a} * {{8{er[48]}}, er};
      pwb <= {{49{item.sample_b[7]}}, item.sample_b} * {{8{er[48]}}, er};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wa     <= alt_pkg::RST_WEIGHT;
      wb     <= alt_pkg::RST_WEIGHT;
      bias   <= alt_pkg::RST_BIAS;
      esum   <= '0;
      ecount <= 8'd1;
      done   <= 1'b0;
    end else if (ctl.restart) begin
      wa     <= init_weight;
      wb     <= init_weight;
      bias   <= init_bias;
      esum   <= '0;
      ecount <= 8'd1;
      done   <= 1'b0;
    end else if (ctl.upd && train) begin
      wa   <= sat32({{23{pwa_r[56]}}, pwa_r[56:16]} + {{32{wa[31]}}, wa});
      wb   <= sat32({{23{pwb_r[56]}}, pwb_r[56:16]} + {{32{wb[31]}}, wb});
      bias <= sat32({{31{er_r[48]}}, er_r[48:16]} + {{32{bias[31]}}, bias});
      esum <= sum_add[alt_pkg::SumW] ? '1 : sum_add[alt_pkg::SumW-1:0];
    end else if (ctl.fin) begin
      if (stop) begin
        done <= 1'b1;
      end else if (epoch_end) begin
        esum <= '0;
        if (ecount != 8'hff) ecount <= ecount + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.fin) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // report the epoch sum and number before the epoch-end bookkeeping
  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      result.net_value    <= net;
      result.error_value  <= err;
      result.weight_a     <= wa;
      result.weight_b     <= wb;
      result.bias_value   <= bias;
      result.epoch_error  <= esum;
      result.epoch_number <= ecount;
      result.done_res     <= done || stop;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/adaline_lms_trainer.sv
`default_nettype none
// channel   signals                                  direction
// sample    sample_valid, sample_ready, sample       in (training or restart word)
// result    result_valid, result_ready, result       out (one word per sample word)
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  in (register writes)
//
// a training word goes through products, net, error, rate product, update
// products, update and finish (two multiplies in products, three in update
// products, one in rate product), a restart word through restart and finish;
// the next word is taken in idle after finish, so not before the last is done
// reset sets the weights to their defaults, the epoch count to one, done to zero
// finish waits only while an older result still sits unread in the output register
module adaline_lms_trainer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          sample_valid,
  output logic               sample_ready,
  input  wire alt_pkg::in_t  sample,
  output logic               result_valid,
  input  wire logic          result_ready,
  output alt_pkg::out_t      result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [47:0]   cfg_data
);

  alt_pkg::ctl_t ctl;
  alt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  alt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .start_mode   (sample.mode),
    .sample_ready (sample_ready),
    .sts          (sts),
    .ctl          (ctl)
  );

  alt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .ctl          (ctl),
    .sts          (sts)
  );

endmodule
`default_nettype wire
